// File: rtl/xcr_pkg.sv
`timescale 1ns / 1ps

package xcr_pkg;

   localparam int FRAME_BYTES_DEF = 133;
   localparam int CRC_BYTES_DEF   = 130;

   localparam logic [7:0] SESSION_RETRIES_RST  = 8'd255;
   localparam logic [7:0] RESUME_RETRIES_RST   = 8'd200;
   localparam logic [7:0] RESPONSE_RETRIES_RST = 8'd100;

   localparam logic [7:0] CH_C   = 8'h43;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_CAN = 8'h18;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [1:0] FUNC_BYTE    = 2'd0;
   localparam logic [1:0] FUNC_GAP     = 2'd1;
   localparam logic [1:0] FUNC_TIMEOUT = 2'd2;
   localparam logic [1:0] FUNC_START   = 2'd3;

   localparam logic [1:0] CSR_SESSION_RETRIES  = 2'd0;
   localparam logic [1:0] CSR_RESUME_RETRIES   = 2'd1;
   localparam logic [1:0] CSR_RESPONSE_RETRIES = 2'd2;

   typedef enum logic [1:0] {
      OP_BYTE,
      OP_GAP,
      OP_TIMEOUT,
      OP_START
   } op_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       payload_valid;
      logic [6:0] payload_pos;
      logic [7:0] payload_byte;
      logic       packet_ok;
      logic       packet_bad;
      logic       finished;
      logic       eot_ok;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] session_retries;
      logic [7:0] resume_retries;
      logic [7:0] response_retries;
   } cfg_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// File: rtl/xcr_front.sv
`timescale 1ns / 1ps

module xcr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  xcr_pkg::req_type   req_data,
   output logic               item_valid,
   input  logic               item_take,
   output xcr_pkg::item_type  item_data
);

   xcr_pkg::item_type mem_ff [2];
   logic [1:0]        count_ff, count_in;
   logic              wr_ptr_ff, rd_ptr_ff;
   logic              push, pop;
   xcr_pkg::item_type classified;

   always_comb begin
      classified.rx_byte = req_data.rx_byte;
      unique case (req_data.func)
         xcr_pkg::FUNC_BYTE:    classified.op = xcr_pkg::OP_BYTE;
         xcr_pkg::FUNC_GAP:     classified.op = xcr_pkg::OP_GAP;
         xcr_pkg::FUNC_TIMEOUT: classified.op = xcr_pkg::OP_TIMEOUT;
         default:               classified.op = xcr_pkg::OP_START;
      endcase
   end

   assign req_full   = (count_ff == 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item_data  = mem_ff[rd_ptr_ff];
   assign push       = req_push && !req_full;
   assign pop        = item_valid && item_take;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// File: rtl/xcr_back.sv
`timescale 1ns / 1ps

module xcr_back #(
   parameter int FRAME_BYTES = xcr_pkg::FRAME_BYTES_DEF,
   parameter int CRC_BYTES   = xcr_pkg::CRC_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  xcr_pkg::cfg_type   cfg,
   input  logic               item_valid,
   output logic               item_take,
   input  xcr_pkg::item_type  item_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output xcr_pkg::rsp_type   rsp_data
);

   localparam int FC_W = $clog2(FRAME_BYTES + 1);

   logic             active_ff, active_in;
   logic             started_ff, started_in;
   logic [7:0]       expected_ff, expected_in;
   logic [7:0]       last_cmd_ff, last_cmd_in;
   logic [FC_W-1:0]  fc_ff, fc_in;
   logic [7:0]       hdr_ff, hdr_in;
   logic [7:0]       num_ff, num_in;
   logic [7:0]       inv_ff, inv_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       session_ff, session_in;
   logic [7:0]       reply_ff, reply_in;

   xcr_pkg::rsp_type res;
   xcr_pkg::rsp_type mem_ff [2];
   logic [1:0]       count_ff, count_in;
   logic             wr_ptr_ff, rd_ptr_ff;
   logic             pop;

   logic [7:0]       reply_reload;

   assign reply_reload = (cfg.response_retries != 8'd0) ?
                         cfg.response_retries - 8'd1 : 8'd0;

   always_comb begin
      logic       do_end;
      logic [7:0] cmd;
      logic [7:0] sl;
      active_in   = active_ff;
      started_in  = started_ff;
      expected_in = expected_ff;
      last_cmd_in = last_cmd_ff;
      fc_in       = fc_ff;
      hdr_in      = hdr_ff;
      num_in      = num_ff;
      inv_in      = inv_ff;
      crc_in      = crc_ff;
      session_in  = session_ff;
      reply_in    = reply_ff;
      res         = '0;
      do_end      = 1'b0;
      cmd         = xcr_pkg::CH_NAK;
      sl          = session_ff;

      priority if (item_data.op == xcr_pkg::OP_START) begin
         active_in   = 1'b1;
         started_in  = 1'b0;
         expected_in = 8'd1;
         session_in  = cfg.session_retries;
         fc_in       = '0;
         hdr_in      = '0;
         num_in      = '0;
         inv_in      = '0;
         crc_in      = '0;
         last_cmd_in = xcr_pkg::CH_C;
         reply_in    = reply_reload;
         res.tx_valid = 1'b1;
         res.tx_byte  = xcr_pkg::CH_C;
      end else if (!active_ff) begin
         res = '0;
      end else if (item_data.op == xcr_pkg::OP_BYTE) begin
         if (32'(fc_ff) < 32'(FRAME_BYTES)) begin
            priority if (fc_ff == FC_W'(0)) begin
               hdr_in = item_data.rx_byte;
            end else if (fc_ff == FC_W'(1)) begin
               num_in = item_data.rx_byte;
            end else if (fc_ff == FC_W'(2)) begin
               inv_in = item_data.rx_byte;
            end else begin
               if (32'(fc_ff) < 32'(CRC_BYTES + 3)) begin
                  crc_in = xcr_pkg::crc_byte(crc_ff, item_data.rx_byte);
               end
               if (32'(fc_ff) < 32'(CRC_BYTES + 1)) begin
                  res.payload_valid = 1'b1;
                  res.payload_pos   = 7'(fc_ff - FC_W'(3));
                  res.payload_byte  = item_data.rx_byte;
               end
            end
            fc_in = fc_ff + FC_W'(1);
         end
      end else if (fc_ff != '0) begin
         do_end = 1'b1;
      end else begin
         if (item_data.op == xcr_pkg::OP_TIMEOUT) begin
            if (reply_ff != 8'd0) begin
               reply_in     = reply_ff - 8'd1;
               res.tx_valid = 1'b1;
               res.tx_byte  = last_cmd_ff;
            end else begin
               do_end = 1'b1;
            end
         end
      end

      if (do_end) begin
         if (32'(fc_ff) == 32'(FRAME_BYTES)) begin
            if (num_ff == expected_ff && inv_ff == ~expected_ff) begin
               started_in = 1'b1;
               sl         = cfg.resume_retries;
               if (crc_ff == 16'd0) begin
                  expected_in   = expected_ff + 8'd1;
                  cmd           = xcr_pkg::CH_ACK;
                  res.packet_ok = 1'b1;
               end
            end
         end else if (!started_ff) begin
            cmd         = xcr_pkg::CH_C;
            expected_in = 8'd1;
            if (sl != 8'd0) begin
               sl = sl - 8'd1;
            end
         end else begin
            if (sl != 8'd0) begin
               sl = sl - 8'd1;
            end
         end
         session_in = sl;
         fc_in      = '0;
         hdr_in     = '0;
         num_in     = '0;
         inv_in     = '0;
         crc_in     = '0;
         res.tx_valid = 1'b1;
         if (hdr_ff == xcr_pkg::CH_EOT || hdr_ff == xcr_pkg::CH_CAN || sl == 8'd0) begin
            active_in    = 1'b0;
            res.tx_byte  = xcr_pkg::CH_ACK;
            res.finished = 1'b1;
            res.eot_ok   = (hdr_ff == xcr_pkg::CH_EOT);
         end else begin
            res.packet_bad = (cmd == xcr_pkg::CH_NAK);
            res.tx_byte    = cmd;
            last_cmd_in    = cmd;
            reply_in       = reply_reload;
         end
      end
   end

   assign item_take = item_valid && (count_ff != 2'd2);
   assign rsp_empty = (count_ff == 2'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_pop && !rsp_empty;

   always_comb begin
      count_in = count_ff;
      if (item_take && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !item_take) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         started_ff  <= 1'b0;
         expected_ff <= 8'd1;
         last_cmd_ff <= xcr_pkg::CH_C;
         fc_ff       <= '0;
         hdr_ff      <= '0;
         num_ff      <= '0;
         inv_ff      <= '0;
         crc_ff      <= '0;
         session_ff  <= xcr_pkg::SESSION_RETRIES_RST;
         reply_ff    <= xcr_pkg::RESPONSE_RETRIES_RST;
         count_ff    <= '0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (item_take) begin
            wr_ptr_ff   <= !wr_ptr_ff;
            active_ff   <= active_in;
            started_ff  <= started_in;
            expected_ff <= expected_in;
            last_cmd_ff <= last_cmd_in;
            fc_ff       <= fc_in;
            hdr_ff      <= hdr_in;
            num_ff      <= num_in;
            inv_ff      <= inv_in;
            crc_ff      <= crc_in;
            session_ff  <= session_in;
            reply_ff    <= reply_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         mem_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

// File: rtl/xmodem_crc_receiver.sv
`timescale 1ns / 1ps

// XMODEM-CRC receiver.
// Input channel: req_push / req_full with req_data {func, rx_byte}. func picks
// a received byte, an inter-byte gap, a reply timeout or a session start.
// Result channel: rsp_empty / rsp_pop with rsp_data; every input item gives
// exactly one result item, in order: a byte to send ('C', ACK, NAK), a data
// byte with its frame position, and packet_ok / packet_bad / finished flags.
// Config channel: csr_valid / csr_ready (always ready), csr_index 0..2 selects
// session, resume and response retry limits; write only while idle.
// Order: an accepted item is written into the front queue; the frame engine
// takes it from there when the result queue has room and writes its result
// into the result queue, from which it can be popped.
// Throughput: one item per cycle while the result queue has room; the frame
// engine folds each data and CRC byte into the CRC-16 as it arrives.
// Reset clears both queues, ends any session and restores the register
// defaults (255, 200, 100). When the result side stalls, the two-entry
// result queue fills, the engine stops, the front queue fills and req_full
// rises; nothing is dropped.
module xmodem_crc_receiver #(
   parameter int FRAME_BYTES = xcr_pkg::FRAME_BYTES_DEF,
   parameter int CRC_BYTES   = xcr_pkg::CRC_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  xcr_pkg::req_type  req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output xcr_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data
);

   xcr_pkg::cfg_type  cfg_ff;
   logic              item_valid;
   logic              item_take;
   xcr_pkg::item_type item_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.session_retries  <= xcr_pkg::SESSION_RETRIES_RST;
         cfg_ff.resume_retries   <= xcr_pkg::RESUME_RETRIES_RST;
         cfg_ff.response_retries <= xcr_pkg::RESPONSE_RETRIES_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            xcr_pkg::CSR_SESSION_RETRIES:  cfg_ff.session_retries  <= csr_data;
            xcr_pkg::CSR_RESUME_RETRIES:   cfg_ff.resume_retries   <= csr_data;
            xcr_pkg::CSR_RESPONSE_RETRIES: cfg_ff.response_retries <= csr_data;
            default: ;
         endcase
      end
   end

   xcr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item_data  (item_data)
   );

   xcr_back #(
      .FRAME_BYTES (FRAME_BYTES),
      .CRC_BYTES   (CRC_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_take  (item_take),
      .item_data  (item_data),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_finish_ack: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.finished) |->
         (rsp_data.tx_valid && rsp_data.tx_byte == xcr_pkg::CH_ACK))
      else $error("finished without final ACK");

   a_ok_ack: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.packet_ok) |->
         (rsp_data.tx_valid && rsp_data.tx_byte == xcr_pkg::CH_ACK && !rsp_data.packet_bad))
      else $error("packet_ok without ACK");

   a_payload_quiet: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.payload_valid) |->
         (!rsp_data.tx_valid && !rsp_data.finished && !rsp_data.packet_ok))
      else $error("data byte result carries frame-end fields");

   a_take_room: assert property (@(posedge clock) disable iff (reset)
      (item_take && rsp_empty) |=> !rsp_empty)
      else $error("engine result lost");

endmodule

// File: test/xmodem_crc_receiver_tb.sv
`timescale 1ns / 1ps

module xmodem_crc_receiver_tb;

   localparam int MAX_REPORTS   = 10;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int ITEM_TARGET   = 750;
   localparam int FINAL_RESERVE = 100;
   localparam logic [7:0] HDR_SOH = 8'h01;

   typedef enum int {
      FR_GOOD,
      FR_BAD_CRC,
      FR_BAD_NUM,
      FR_BAD_INV,
      FR_DUP,
      FR_SHORT,
      FR_LONG,
      FR_ODD_HDR,
      FR_NOISE,
      FR_RESTART,
      FR_EOT,
      FR_CAN
   } frame_kind_type;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_push  = 1'b0;
   logic             req_full;
   xcr_pkg::req_type req_data  = '0;
   logic             rsp_empty;
   logic             rsp_pop   = 1'b0;
   xcr_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = xcr_pkg::CSR_SESSION_RETRIES;
   logic [7:0]       csr_data  = 8'h00;

   // receiver model state
   xcr_pkg::cfg_type cfg_shadow;
   logic        rx_active;
   logic        rx_started;
   logic [7:0]  want_num;
   logic [7:0]  last_cmd;
   int          frame_len;
   logic [7:0]  hdr_byte;
   logic [7:0]  num_byte;
   logic [7:0]  num_inv_byte;
   logic [15:0] crc_acc;
   logic [7:0]  session_cnt;
   logic [7:0]  reply_cnt;

   xcr_pkg::rsp_type rsp_expect[$];

   bit idle_en     = 1'b1;
   int hold_cycles = 0;
   int items_sent   = 0;
   int results_seen = 0;
   int fail_count   = 0;
   int good_frames  = 0;
   int bad_frames   = 0;
   int session_ends = 0;
   int full_stalls  = 0;

   xmodem_crc_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[15] ^ b[i];
         c  = {c[14:0], 1'b0} ^ (fb ? xcr_pkg::CRC_POLY : 16'h0000);
      end
      return c;
   endfunction

   function automatic void clear_frame_state();
      frame_len    = 0;
      hdr_byte     = 8'h00;
      num_byte     = 8'h00;
      num_inv_byte = 8'h00;
      crc_acc      = 16'h0000;
   endfunction

   function automatic xcr_pkg::rsp_type command_result(input logic [7:0] cmd);
      xcr_pkg::rsp_type o;
      o = '0;
      last_cmd  = cmd;
      reply_cnt = (cfg_shadow.response_retries > 0) ? cfg_shadow.response_retries - 8'd1 : 8'd0;
      o.tx_valid = 1'b1;
      o.tx_byte  = cmd;
      return o;
   endfunction

   function automatic xcr_pkg::rsp_type close_frame();
      xcr_pkg::rsp_type o;
      logic [7:0] cmd;
      logic [7:0] hdr;
      logic       ok;
      hdr = hdr_byte;
      ok  = 1'b0;
      if (frame_len == xcr_pkg::FRAME_BYTES_DEF) begin
         if (num_byte == want_num && num_inv_byte == ~want_num) begin
            rx_started  = 1'b1;
            session_cnt = cfg_shadow.resume_retries;
            if (crc_acc == 16'h0000) begin
               want_num = want_num + 8'd1;
               cmd      = xcr_pkg::CH_ACK;
               ok       = 1'b1;
            end else begin
               cmd = xcr_pkg::CH_NAK;
            end
         end else begin
            cmd = xcr_pkg::CH_NAK;
         end
      end else if (!rx_started) begin
         cmd      = xcr_pkg::CH_C;
         want_num = 8'd1;
         if (session_cnt > 0) session_cnt = session_cnt - 8'd1;
      end else begin
         cmd = xcr_pkg::CH_NAK;
         if (session_cnt > 0) session_cnt = session_cnt - 8'd1;
      end
      clear_frame_state();
      if (hdr == xcr_pkg::CH_EOT || hdr == xcr_pkg::CH_CAN || session_cnt == 0) begin
         rx_active  = 1'b0;
         o          = '0;
         o.tx_valid = 1'b1;
         o.tx_byte  = xcr_pkg::CH_ACK;
         o.finished = 1'b1;
         o.eot_ok   = (hdr == xcr_pkg::CH_EOT);
      end else begin
         o            = command_result(cmd);
         o.packet_bad = (cmd == xcr_pkg::CH_NAK);
      end
      o.packet_ok = ok;
      return o;
   endfunction

   function automatic xcr_pkg::rsp_type receiver_step(input xcr_pkg::req_type r);
      xcr_pkg::rsp_type o;
      int      pos;
      o = '0;
      if (xcr_pkg::op_type'(r.func) == xcr_pkg::OP_START) begin
         rx_active   = 1'b1;
         rx_started  = 1'b0;
         want_num    = 8'd1;
         session_cnt = cfg_shadow.session_retries;
         clear_frame_state();
         o = command_result(xcr_pkg::CH_C);
      end else if (rx_active) begin
         if (xcr_pkg::op_type'(r.func) == xcr_pkg::OP_BYTE) begin
            if (frame_len < xcr_pkg::FRAME_BYTES_DEF) begin
               if (frame_len == 0) hdr_byte = r.rx_byte;
               else if (frame_len == 1) num_byte = r.rx_byte;
               else if (frame_len == 2) num_inv_byte = r.rx_byte;
               else begin
                  if (frame_len < xcr_pkg::CRC_BYTES_DEF + 3)
                     crc_acc = crc16_step(crc_acc, r.rx_byte);
                  if (frame_len < xcr_pkg::CRC_BYTES_DEF + 1) begin
                     pos = frame_len - 3;
                     o.payload_valid = 1'b1;
                     o.payload_pos   = pos[6:0];
                     o.payload_byte  = r.rx_byte;
                  end
               end
               frame_len++;
            end
         end else if (frame_len > 0) begin
            o = close_frame();
         end else if (xcr_pkg::op_type'(r.func) == xcr_pkg::OP_TIMEOUT) begin
            if (reply_cnt > 0) begin
               reply_cnt  = reply_cnt - 8'd1;
               o.tx_valid = 1'b1;
               o.tx_byte  = last_cmd;
            end else begin
               o = close_frame();
            end
         end
      end
      return o;
   endfunction

   function automatic string rsp_text(input xcr_pkg::rsp_type r);
      return $sformatf("tx %b/%h data %b/%0d/%h ok %b bad %b fin %b eot %b",
                       r.tx_valid, r.tx_byte, r.payload_valid, r.payload_pos,
                       r.payload_byte, r.packet_ok, r.packet_bad, r.finished, r.eot_ok);
   endfunction

   task automatic send_item(input xcr_pkg::op_type op, input logic [7:0] b);
      xcr_pkg::req_type r;
      xcr_pkg::rsp_type res;
      r.func    = op;
      r.rx_byte = b;
      if (idle_en && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      res = receiver_step(r);
      rsp_expect.push_back(res);
      items_sent++;
      if (res.packet_ok) good_frames++;
      if (res.packet_bad) bad_frames++;
      if (res.finished) session_ends++;
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (rsp_expect.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         xcr_pkg::CSR_SESSION_RETRIES:  cfg_shadow.session_retries  = val;
         xcr_pkg::CSR_RESUME_RETRIES:   cfg_shadow.resume_retries   = val;
         xcr_pkg::CSR_RESPONSE_RETRIES: cfg_shadow.response_retries = val;
         default: ;
      endcase
   endtask

   task automatic set_retries(input logic [7:0] sess, input logic [7:0] resume,
                              input logic [7:0] resp);
      wait_idle();
      csr_write(xcr_pkg::CSR_SESSION_RETRIES, sess);
      csr_write(xcr_pkg::CSR_RESUME_RETRIES, resume);
      csr_write(xcr_pkg::CSR_RESPONSE_RETRIES, resp);
      csr_valid <= 1'b0;
   endtask

   // one frame of the given kind, ended by a gap, timeout or start
   task automatic send_frame(input frame_kind_type kind);
      logic [7:0]  fbytes[$];
      logic [7:0]  blk;
      logic [7:0]  hdr;
      logic [7:0]  d;
      logic [15:0] crc;
      int          len;
      int          idx;
      if (kind == FR_NOISE) begin
         repeat ($urandom_range(1, 3))
            send_item($urandom_range(0, 1) ? xcr_pkg::OP_TIMEOUT : xcr_pkg::OP_GAP, rnd8());
         return;
      end
      blk = want_num;
      if (kind == FR_DUP) blk = want_num - 8'd1;
      if (kind == FR_BAD_NUM) blk = want_num ^ (8'd1 << $urandom_range(0, 7));
      hdr = HDR_SOH;
      if (kind == FR_ODD_HDR) begin
         do hdr = rnd8(); while (hdr == xcr_pkg::CH_EOT || hdr == xcr_pkg::CH_CAN);
      end
      if (kind == FR_EOT) hdr = xcr_pkg::CH_EOT;
      if (kind == FR_CAN) hdr = xcr_pkg::CH_CAN;
      fbytes.push_back(hdr);
      fbytes.push_back(blk);
      fbytes.push_back(kind == FR_BAD_INV ? ~blk ^ (8'd1 << $urandom_range(0, 7)) : ~blk);
      crc = 16'h0000;
      for (int i = 0; i < 128; i++) begin
         d = rnd8();
         fbytes.push_back(d);
         crc = crc16_step(crc, d);
      end
      fbytes.push_back(crc[15:8]);
      fbytes.push_back(crc[7:0]);
      if (kind == FR_BAD_CRC) begin
         idx = $urandom_range(3, xcr_pkg::FRAME_BYTES_DEF - 1);
         fbytes[idx] = fbytes[idx] ^ (8'd1 << $urandom_range(0, 7));
      end
      len = fbytes.size();
      case (kind)
         FR_SHORT:   len = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 132)
                                                     : $urandom_range(1, 8);
         FR_RESTART: len = $urandom_range(1, 132);
         FR_EOT, FR_CAN: if ($urandom_range(0, 3) != 0) len = 1;
         FR_LONG: begin
            repeat ($urandom_range(1, 6)) fbytes.push_back(rnd8());
            len = fbytes.size();
         end
         default: ;
      endcase
      for (int i = 0; i < len; i++) send_item(xcr_pkg::OP_BYTE, fbytes[i]);
      if (kind == FR_RESTART) send_item(xcr_pkg::OP_START, rnd8());
      else send_item($urandom_range(0, 4) == 0 ? xcr_pkg::OP_TIMEOUT : xcr_pkg::OP_GAP,
                     rnd8());
   endtask

   task automatic run_session(input int frames);
      frame_kind_type kind;
      int        pick;
      send_item(xcr_pkg::OP_START, rnd8());
      for (int n = 0; n < frames && rx_active; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) kind = FR_GOOD;
         else if (pick < 48) kind = FR_BAD_CRC;
         else if (pick < 53) kind = FR_BAD_NUM;
         else if (pick < 58) kind = FR_BAD_INV;
         else if (pick < 62) kind = FR_DUP;
         else if (pick < 74) kind = FR_SHORT;
         else if (pick < 78) kind = FR_LONG;
         else if (pick < 82) kind = FR_ODD_HDR;
         else if (pick < 88) kind = FR_NOISE;
         else if (pick < 91) kind = FR_RESTART;
         else if (pick < 96) kind = FR_EOT;
         else kind = FR_CAN;
         send_frame(kind);
      end
   endtask

   task automatic test_idle_inputs();
      send_item(xcr_pkg::OP_BYTE, 8'h00);
      send_item(xcr_pkg::OP_BYTE, 8'hff);
      send_item(xcr_pkg::OP_GAP, 8'hff);
      send_item(xcr_pkg::OP_TIMEOUT, 8'h00);
      send_item(xcr_pkg::OP_START, 8'h00);
      send_item(xcr_pkg::OP_GAP, 8'h00);
      send_item(xcr_pkg::OP_TIMEOUT, 8'hff);
   endtask

   task automatic test_reply_timeouts();
      set_retries(8'd2, 8'd1, 8'd3);
      send_item(xcr_pkg::OP_START, rnd8());
      repeat (6) send_item(xcr_pkg::OP_TIMEOUT, rnd8());
      set_retries(8'd1, 8'd1, 8'd1);
      send_item(xcr_pkg::OP_START, rnd8());
      send_item(xcr_pkg::OP_TIMEOUT, rnd8());
      send_item(xcr_pkg::OP_GAP, rnd8());
      send_item(xcr_pkg::OP_START, rnd8());
      send_item(xcr_pkg::OP_BYTE, HDR_SOH);
      send_item(xcr_pkg::OP_BYTE, 8'h01);
      send_item(xcr_pkg::OP_TIMEOUT, rnd8());
   endtask

   task automatic test_frame_kinds();
      frame_kind_type walk [0:4];
      walk = '{FR_GOOD, FR_BAD_CRC, FR_SHORT, FR_NOISE, FR_CAN};
      set_retries(8'd255, 8'd255, 8'd255);
      send_item(xcr_pkg::OP_START, rnd8());
      foreach (walk[i]) send_frame(walk[i]);
      send_item(xcr_pkg::OP_BYTE, rnd8());
      send_item(xcr_pkg::OP_START, rnd8());
      send_frame(FR_EOT);
   endtask

   task automatic test_backpressure();
      set_retries(8'd3, 8'd2, 8'd2);
      send_item(xcr_pkg::OP_START, rnd8());
      hold_cycles = HOLD_CYCLES;
      send_frame(FR_GOOD);
   endtask

   task automatic test_random_sessions();
      int mode;
      while (items_sent < ITEM_TARGET - FINAL_RESERVE) begin
         mode = $urandom_range(0, 5);
         case (mode)
            0: set_retries(8'd1, 8'd1, 8'd1);
            1: set_retries(8'd255, 8'd255, 8'd255);
            2, 3: set_retries(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                              8'($urandom_range(1, 4)));
            default: set_retries(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                                 8'($urandom_range(1, 255)));
         endcase
         run_session($urandom_range(1, 2));
      end
   endtask

   task automatic test_final_session();
      set_retries(xcr_pkg::SESSION_RETRIES_RST, xcr_pkg::RESUME_RETRIES_RST,
                  xcr_pkg::RESPONSE_RETRIES_RST);
      send_item(xcr_pkg::OP_START, rnd8());
      send_frame(FR_SHORT);
      send_frame(FR_EOT);
   endtask

   initial begin : pop_driver
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_pop <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else if (idle_en && $urandom_range(0, 9) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(0, 15)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_results
      xcr_pkg::rsp_type want;
      if (!reset && req_push && req_full) full_stalls++;
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen++;
         if (rsp_expect.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("unexpected result: %s", rsp_text(rsp_data));
            fail_count++;
         end else begin
            want = rsp_expect.pop_front();
            if (rsp_data !== want) begin
               if (fail_count < MAX_REPORTS) begin
                  $display("result %0d mismatch", results_seen);
                  $display("  expected %s", rsp_text(want));
                  $display("  actual   %s", rsp_text(rsp_data));
               end
               fail_count++;
            end
         end
      end
   end

   initial begin : run_limit
      #2_000_000;
      $display("timeout: %0d results still expected", rsp_expect.size());
      $display("xmodem_crc_receiver_tb failed");
      $finish;
   end

   initial begin : main_flow
      cfg_shadow  = '{xcr_pkg::SESSION_RETRIES_RST, xcr_pkg::RESUME_RETRIES_RST,
                      xcr_pkg::RESPONSE_RETRIES_RST};
      rx_active   = 1'b0;
      rx_started  = 1'b0;
      want_num    = 8'd1;
      last_cmd    = xcr_pkg::CH_C;
      session_cnt = 8'd255;
      reply_cnt   = 8'd100;
      clear_frame_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_idle_inputs();
      test_reply_timeouts();
      test_frame_kinds();
      test_backpressure();
      test_random_sessions();
      idle_en = 1'b0;
      test_final_session();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d items and %0d results: %0d good frames, %0d rejected, %0d ends",
               items_sent, results_seen, good_frames, bad_frames, session_ends);
      $display("input stalled on a full queue for %0d cycles, %0d failures",
               full_stalls, fail_count);
      if (fail_count == 0 && rsp_expect.size() == 0) begin
         $display("xmodem_crc_receiver_tb passed");
      end else begin
         $display("xmodem_crc_receiver_tb failed");
      end
      $finish;
   end

endmodule
